// File: rtl/core/flnta_pkg.sv
// Shared types, codes and constants for the fixed-length number to ASCII formatter.
// No dependencies; every other file in rtl/core refers to this package by scoped names.
`default_nettype none

package flnta_pkg;

    localparam int MAX_DIGITS_DEF = 16;
    localparam int DEC_MAX        = 10;
    localparam int HEX_MAX        = 8;
    localparam int BIN_CAP        = 32;

    localparam int VALUE_W        = 32;
    localparam int COUNT_W        = 5;
    localparam int CHAR_W         = 7;
    localparam int BCD_DIGITS     = 10;
    localparam int BCD_W          = 4 * BCD_DIGITS;
    localparam int STEP_W         = $clog2(VALUE_W);
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_UPPER = 7'h41;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 7'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;

    typedef enum logic [1:0] {
        OP_UDEC = 2'd0,
        OP_SDEC = 2'd1,
        OP_HEX  = 2'd2,
        OP_BIN  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_EMIT
    } back_state_t;

    // One classified job as it waits in the queue.
    typedef struct packed {
        opcode_t              opcode;
        logic                 neg;
        logic [VALUE_W-1:0]   mag;
        logic [COUNT_W-1:0]   count;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/fixed_length_number_to_ascii.sv
// Decimal formats pass from the job queue through a pop, 32 shift-and-add-3 steps and the output
// register before the first character is valid; hex and binary skip the conversion steps.
// Characters follow one per cycle while the receiver is ready.
// The back end formats one number at a time and pops the next only when idle; meanwhile the
// job queue goes on accepting beats until it is full.
// Reset (rst_n low, asynchronous) empties the two-entry job queue and drops any run in flight.
// Top level of the formatter; depends on flnta_pkg, flnta_front, flnta_queue and flnta_back.
`default_nettype none

module fixed_length_number_to_ascii #(
    parameter int MAX_DIGITS = flnta_pkg::MAX_DIGITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // value[31:0], digit_count[36:32], zeros above
    input  wire logic [1:0]  s_axis_tuser,   // opcode[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // ascii_char[6:0], char_offset[11:7], zeros above
    output logic             m_axis_tlast    // last
);

    flnta_pkg::queue_stat_t              stat;
    flnta_pkg::job_t                     push_job;
    flnta_pkg::job_t                     pop_job;
    logic                                push;
    logic                                pop;
    logic [flnta_pkg::CHAR_W-1:0]        ascii_char;
    logic [flnta_pkg::COUNT_W-1:0]       char_offset;

    flnta_front #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_front (
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .opcode      (flnta_pkg::opcode_t'(s_axis_tuser)),
        .value       (s_axis_tdata[31:0]),
        .digit_count (s_axis_tdata[36:32]),
        .stat        (stat),
        .push        (push),
        .job         (push_job)
    );

    flnta_queue #(
        .DEPTH (flnta_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .stat     (stat)
    );

    flnta_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .stat       (stat),
        .job_in     (pop_job),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_char   (ascii_char),
        .out_offset (char_offset),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, char_offset, ascii_char};

endmodule

`default_nettype wire

// File: rtl/core/flnta_front.sv
// Front end: accepts input beats, clamps the digit count, splits sign from magnitude and drops empty runs.
// Depends on flnta_pkg; feeds flnta_queue.
`default_nettype none

module flnta_front #(
    parameter int MAX_DIGITS = flnta_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire flnta_pkg::opcode_t             opcode,
    input  wire logic [flnta_pkg::VALUE_W-1:0]  value,
    input  wire logic [flnta_pkg::COUNT_W-1:0]  digit_count,
    input  wire flnta_pkg::queue_stat_t         stat,
    output logic                                push,
    output flnta_pkg::job_t                     job
);

    localparam int BIN_LIM = (MAX_DIGITS > flnta_pkg::BIN_CAP) ? flnta_pkg::BIN_CAP : MAX_DIGITS;

    logic [flnta_pkg::COUNT_W:0] lim;
    logic [flnta_pkg::COUNT_W:0] cnt_wide;
    logic [flnta_pkg::COUNT_W:0] cnt_clamped;
    logic                        neg;
    logic                        drop;

    always_comb
    begin
        unique case (opcode)
            flnta_pkg::OP_UDEC: lim = (flnta_pkg::COUNT_W + 1)'(flnta_pkg::DEC_MAX);
            flnta_pkg::OP_SDEC: lim = (flnta_pkg::COUNT_W + 1)'(flnta_pkg::DEC_MAX);
            flnta_pkg::OP_HEX:  lim = (flnta_pkg::COUNT_W + 1)'(flnta_pkg::HEX_MAX);
            flnta_pkg::OP_BIN:  lim = (flnta_pkg::COUNT_W + 1)'(BIN_LIM);
            default:            lim = '0;
        endcase
    end

    assign cnt_wide    = {1'b0, digit_count};
    assign cnt_clamped = (cnt_wide > lim) ? lim : cnt_wide;
    assign neg         = (opcode == flnta_pkg::OP_SDEC) && value[flnta_pkg::VALUE_W-1];
    // Formats without a sign character produce nothing for a zero count: drop the beat.
    assign drop        = (opcode != flnta_pkg::OP_SDEC) && (cnt_clamped == '0);

    always_comb
    begin
        job.opcode = opcode;
        job.neg    = neg;
        job.mag    = neg ? (~value + flnta_pkg::VALUE_W'(1)) : value;
        job.count  = cnt_clamped[flnta_pkg::COUNT_W-1:0];
    end

    assign in_ready = !stat.full;
    assign push     = in_valid && !stat.full && !drop;

endmodule

`default_nettype wire

// File: rtl/core/flnta_queue.sv
// Short job queue between front end and back end.
// Depends on flnta_pkg for the job and status types.
`default_nettype none

module flnta_queue #(
    parameter int DEPTH = flnta_pkg::QUEUE_DEPTH
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire flnta_pkg::job_t        push_job,
    input  wire logic                   pop,
    output flnta_pkg::job_t             pop_job,
    output flnta_pkg::queue_stat_t      stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    flnta_pkg::job_t  entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_push;
    logic             do_pop;

    assign do_push = push && (fill_reg != CNT_W'(DEPTH));
    assign do_pop  = pop && (fill_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign pop_job    = entry_reg[rd_ptr_reg];
    assign stat.full  = (fill_reg == CNT_W'(DEPTH));
    assign stat.empty = (fill_reg == '0);

endmodule

`default_nettype wire

// File: rtl/core/flnta_back.sv
// Back end: shift-and-add-3 binary to BCD conversion for decimal formats, then one character
// per cycle into an output register unless stalled. Depends on flnta_pkg; pops jobs from flnta_queue.
`default_nettype none

module flnta_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire flnta_pkg::queue_stat_t         stat,
    input  wire flnta_pkg::job_t                job_in,
    output logic                                pop,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [flnta_pkg::CHAR_W-1:0]        out_char,
    output logic [flnta_pkg::COUNT_W-1:0]       out_offset,
    output logic                                out_last
);

    flnta_pkg::back_state_t              state_reg, state_next;
    flnta_pkg::job_t                     job_reg;
    logic [flnta_pkg::BCD_W-1:0]         dig_reg;
    logic [flnta_pkg::VALUE_W-1:0]       sh_reg;
    logic [flnta_pkg::STEP_W-1:0]        step_reg;
    logic [flnta_pkg::COUNT_W-1:0]       pos_reg;
    logic [flnta_pkg::COUNT_W-1:0]       off_reg;
    logic                                out_valid_reg;
    logic [flnta_pkg::CHAR_W-1:0]        out_char_reg;
    logic [flnta_pkg::COUNT_W-1:0]       out_offset_reg;
    logic                                out_last_reg;

    logic                                is_dec;
    logic                                conv_done;
    logic                                emit_go;
    logic [flnta_pkg::BCD_W-1:0]         bcd_adj;
    logic [flnta_pkg::BCD_W-1:0]         dig_shift;
    logic [flnta_pkg::VALUE_W-1:0]       sh_shift;
    logic [flnta_pkg::VALUE_W-1:0]       bin_bits;
    logic [3:0]                          digit;
    logic [flnta_pkg::CHAR_W-1:0]        digit_char;
    logic [flnta_pkg::CHAR_W-1:0]        emit_char;
    logic                                emit_last;

    assign is_dec    = (job_in.opcode == flnta_pkg::OP_UDEC) ||
                       (job_in.opcode == flnta_pkg::OP_SDEC);
    assign conv_done = (step_reg == flnta_pkg::STEP_W'(flnta_pkg::VALUE_W - 1));

    // Add 3 to every BCD digit of 5 or more, then shift one bit in.
    always_comb
    begin
        for (int i = 0; i < flnta_pkg::BCD_DIGITS; i++)
        begin
            bcd_adj[4*i +: 4] = (dig_reg[4*i +: 4] >= 4'd5) ? dig_reg[4*i +: 4] + 4'd3
                                                             : dig_reg[4*i +: 4];
        end
    end

    assign dig_shift = {bcd_adj[flnta_pkg::BCD_W-2:0], sh_reg[flnta_pkg::VALUE_W-1]};
    assign sh_shift  = {sh_reg[flnta_pkg::VALUE_W-2:0], 1'b0};

    // Digit at position pos_reg: one bit for binary, one nibble otherwise.
    assign bin_bits = dig_reg[flnta_pkg::VALUE_W-1:0];
    assign digit    = (job_reg.opcode == flnta_pkg::OP_BIN) ? {3'b000, bin_bits[pos_reg]}
                                                          : dig_reg[{pos_reg[3:0], 2'b00} +: 4];
    assign digit_char = (digit < 4'd10) ? flnta_pkg::CH_ZERO + {3'b000, digit}
                                        : flnta_pkg::CH_UPPER + {3'b000, digit} - 7'd10;

    // Outputs of the state machine.
    always_comb
    begin
        pop       = 1'b0;
        emit_go   = 1'b0;
        emit_char = digit_char;
        emit_last = (pos_reg == '0);
        unique case (state_reg)
            flnta_pkg::ST_IDLE:
            begin
                pop = !stat.empty;
            end
            flnta_pkg::ST_CONV:
            begin
                pop = 1'b0;
            end
            flnta_pkg::ST_SIGN:
            begin
                emit_go   = !out_valid_reg || out_ready;
                emit_char = job_reg.neg ? flnta_pkg::CH_MINUS : flnta_pkg::CH_PLUS;
                emit_last = (job_reg.count == '0);
            end
            flnta_pkg::ST_EMIT:
            begin
                emit_go = !out_valid_reg || out_ready;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            flnta_pkg::ST_IDLE:
            begin
                if (!stat.empty)
                begin
                    state_next = is_dec ? flnta_pkg::ST_CONV : flnta_pkg::ST_EMIT;
                end
            end
            flnta_pkg::ST_CONV:
            begin
                if (conv_done)
                begin
                    state_next = (job_reg.opcode == flnta_pkg::OP_SDEC) ? flnta_pkg::ST_SIGN
                                                                       : flnta_pkg::ST_EMIT;
                end
            end
            flnta_pkg::ST_SIGN:
            begin
                if (emit_go)
                begin
                    state_next = (job_reg.count == '0) ? flnta_pkg::ST_IDLE
                                                       : flnta_pkg::ST_EMIT;
                end
            end
            flnta_pkg::ST_EMIT:
            begin
                if (emit_go && (pos_reg == '0))
                begin
                    state_next = flnta_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = flnta_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= flnta_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg  <= job_in;
            dig_reg  <= is_dec ? '0 : {{(flnta_pkg::BCD_W - flnta_pkg::VALUE_W){1'b0}}, job_in.mag};
            sh_reg   <= job_in.mag;
            step_reg <= '0;
            pos_reg  <= job_in.count - flnta_pkg::COUNT_W'(1);
            off_reg  <= '0;
        end
        else if (state_reg == flnta_pkg::ST_CONV)
        begin
            dig_reg  <= dig_shift;
            sh_reg   <= sh_shift;
            step_reg <= step_reg + flnta_pkg::STEP_W'(1);
        end
        else if (emit_go)
        begin
            off_reg <= off_reg + flnta_pkg::COUNT_W'(1);
            if (state_reg == flnta_pkg::ST_EMIT)
            begin
                pos_reg <= pos_reg - flnta_pkg::COUNT_W'(1);
            end
        end
        if (emit_go)
        begin
            out_char_reg   <= emit_char;
            out_offset_reg <= off_reg;
            out_last_reg   <= emit_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_char   = out_char_reg;
    assign out_offset = out_offset_reg;
    assign out_last   = out_last_reg;

endmodule

`default_nettype wire

// File: rtl/core/flnta_checker.sv
// Port-level checker for the formatter, bound to the top level.
// Depends on flnta_pkg for the character codes.
`default_nettype none

module flnta_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);

    logic [4:0] exp_off_reg;
    logic       seen_reg;
    logic [6:0] chr;
    logic [4:0] off;

    assign chr = m_axis_tdata[6:0];
    assign off = m_axis_tdata[11:7];

    // Track the offset the next output beat must carry, and whether any input arrived.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_off_reg <= '0;
            seen_reg    <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                exp_off_reg <= m_axis_tlast ? 5'd0 : off + 5'd1;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                seen_reg <= 1'b1;
            end
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    a_offset: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> off == exp_off_reg)
        else $error("character offset out of sequence");

    a_sign_first: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (chr == flnta_pkg::CH_PLUS || chr == flnta_pkg::CH_MINUS)
            |-> off == 5'd0)
        else $error("sign character away from start of run");

    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> seen_reg)
        else $error("output beat without any accepted input");

endmodule

bind fixed_length_number_to_ascii flnta_checker u_flnta_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// File: tb/tb_top.sv
// Testbench for fixed_length_number_to_ascii: directed and random numbers in all four formats.
// A scoreboard class predicts every character beat; depends on flnta_pkg and the RTL top only.
`timescale 1ns / 100ps

module tb_top;

    import flnta_pkg::*;

    localparam int MAX_DIGITS   = MAX_DIGITS_DEF;
    localparam int RANDOM_ITEMS = 210;
    localparam int QUIET_ITEMS  = 40;
    localparam int DRAIN_CYCLES = 100;

    typedef struct {
        logic [CHAR_W-1:0]  ch;
        logic [COUNT_W-1:0] offset;
        logic               last;
    } char_beat_t;

    class ascii_run_scoreboard;
        char_beat_t  pending_chars[$];
        int unsigned error_count;
        int unsigned chars_checked;
        int unsigned numbers_noted;

        // Predict the characters that one accepted number produces.
        function void note_number(opcode_t op, logic [VALUE_W-1:0] value,
                                  logic [COUNT_W-1:0] count);
            int unsigned        limit;
            int unsigned        digits;
            int unsigned        pos;
            int unsigned        digit;
            logic [VALUE_W-1:0] mag;
            logic [VALUE_W-1:0] scale;
            logic [COUNT_W-1:0] offset;
            char_beat_t         beat;

            numbers_noted++;
            case (op)
                OP_HEX:  limit = HEX_MAX;
                OP_BIN:  limit = (MAX_DIGITS > BIN_CAP) ? BIN_CAP : MAX_DIGITS;
                default: limit = DEC_MAX;
            endcase
            digits = (count > limit) ? limit : count;
            mag    = value;
            offset = '0;

            if (op == OP_SDEC)
            begin
                if (value[VALUE_W-1])
                    mag = ~value + 1'b1;
                beat.ch     = value[VALUE_W-1] ? CH_MINUS : CH_PLUS;
                beat.offset = offset;
                beat.last   = (digits == 0);
                pending_chars.push_back(beat);
                offset++;
            end

            for (int i = 0; i < digits; i++)
            begin
                pos = digits - 1 - i;
                case (op)
                    OP_HEX:  digit = (mag >> (4 * pos)) & 4'hF;
                    OP_BIN:  digit = (mag >> pos) & 1'b1;
                    default:
                    begin
                        scale = 1;
                        for (int k = 0; k < pos; k++)
                            scale = scale * 10;
                        digit = (mag / scale) % 10;
                    end
                endcase
                beat.ch     = (digit < 10) ? CHAR_W'(CH_ZERO + digit)
                                           : CHAR_W'(CH_UPPER + (digit - 10));
                beat.offset = offset;
                beat.last   = (i + 1 == digits);
                pending_chars.push_back(beat);
                offset++;
            end
        endfunction

        function void check_char(logic [15:0] data, logic last);
            char_beat_t want;

            chars_checked++;
            if (pending_chars.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected char beat: char %h offset %0d last %b",
                             data[6:0], data[11:7], last);
                return;
            end
            want = pending_chars.pop_front();
            if (data[6:0] !== want.ch || data[11:7] !== want.offset || last !== want.last)
            begin
                error_count++;
                if (error_count <= 10)
                    $display({"mismatch on char %0d: expected char %h offset %0d last %b,",
                              " got char %h offset %0d last %b"},
                             chars_checked, want.ch, want.offset, want.last,
                             data[6:0], data[11:7], last);
            end
        endfunction

        function int unsigned outstanding();
            return pending_chars.size();
        endfunction
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;   // value[31:0], digit_count[36:32], zeros above
    logic [1:0]  s_axis_tuser  = '0;   // opcode[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // ascii_char[6:0], char_offset[11:7], zeros above
    logic        m_axis_tlast;

    ascii_run_scoreboard sb = new();
    bit                  idle_enable = 1'b1;
    int unsigned         stall_left  = 0;

    fixed_length_number_to_ascii #(
        .MAX_DIGITS(MAX_DIGITS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Check output beats and, while idling is enabled, stall the receiver in random bursts.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_char(m_axis_tdata, m_axis_tlast);
            if (!idle_enable)
                m_axis_tready <= 1'b1;
            else if (stall_left != 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 7);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic send_number(opcode_t op, logic [VALUE_W-1:0] value,
                               logic [COUNT_W-1:0] count);
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, count, value};
        s_axis_tuser  <= op;
        // hold the beat until the block takes it
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_number(op, value, count);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 32'h8000_0000;
            3:       return $urandom_range(0, 999);
            4:       return 32'h7FFF_FFFF - $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        opcode_t            op;
        logic [COUNT_W-1:0] count;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, clamping, empty runs and dropped high digits
        send_number(OP_UDEC, 32'h0000_0000, 5'd10);
        send_number(OP_UDEC, 32'hFFFF_FFFF, 5'd10);
        send_number(OP_UDEC, 32'hFFFF_FFFF, 5'd31);
        send_number(OP_UDEC, 32'd1234567890, 5'd4);
        send_number(OP_UDEC, 32'd7, 5'd0);
        send_number(OP_SDEC, 32'h8000_0000, 5'd10);
        send_number(OP_SDEC, 32'h7FFF_FFFF, 5'd10);
        send_number(OP_SDEC, 32'h0000_0000, 5'd1);
        send_number(OP_SDEC, 32'hFFFF_FFFF, 5'd3);
        send_number(OP_SDEC, 32'hFFFF_FFFF, 5'd0);
        send_number(OP_SDEC, 32'd42, 5'd0);
        send_number(OP_SDEC, 32'h8000_0000, 5'd31);
        send_number(OP_HEX,  32'hDEAD_BEEF, 5'd8);
        send_number(OP_HEX,  32'hFFFF_FFFF, 5'd31);
        send_number(OP_HEX,  32'h0123_ABCD, 5'd3);
        send_number(OP_HEX,  32'h1234_5678, 5'd0);
        send_number(OP_BIN,  32'hFFFF_FFFF, 5'd16);
        send_number(OP_BIN,  32'hAAAA_5555, 5'd31);
        send_number(OP_BIN,  32'h0000_0001, 5'd1);
        send_number(OP_BIN,  32'hFFFF_FFFF, 5'd0);
        send_number(OP_BIN,  32'h0000_0000, 5'd17);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // alternate stretches with and without idling; none at the tail
            if (i >= RANDOM_ITEMS - QUIET_ITEMS)
                idle_enable = 1'b0;
            else if (i % 32 == 0)
                idle_enable = ($urandom_range(0, 3) != 0);
            op = opcode_t'($urandom_range(0, 3));
            if ($urandom_range(0, 5) == 0)
                count = COUNT_W'($urandom_range(17, 31));
            else
                count = COUNT_W'($urandom_range(0, 16));
            send_number(op, pick_value(), count);
        end
        s_axis_tvalid <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d numbers in all four formats, checked %0d characters",
                 sb.numbers_noted, sb.chars_checked);
        $display("mismatches: %0d, characters still expected: %0d",
                 sb.error_count, sb.outstanding());
        if (sb.error_count == 0 && sb.outstanding() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("timeout with %0d characters still expected", sb.outstanding());
        $display("TEST FAILED");
        $finish;
    end

endmodule
